FILE: sv/sfsc_pkg.sv
`timescale 1ns / 1ps
package sfsc_pkg;

  localparam int unsigned MaskCount = 7;
  localparam int unsigned MaskW     = 64;
  localparam int unsigned TotalW    = 40;
  localparam int unsigned RptW      = 32;
  localparam int unsigned BaseW     = 2;
  localparam int unsigned CfgIdxW   = 3;

  localparam int unsigned DefaultMaxReadLen = 32 * 1024;
  localparam int unsigned DefaultNumGroups  = 7;

  // TAA, TAG and TGA
  localparam logic [MaskW-1:0]  DefaultStops = 64'h0105_0000_0000_0000;
  localparam logic [TotalW-1:0] TotalMax     = {TotalW{1'b1}};

  typedef logic [MaskW-1:0]     mask_t;
  typedef logic [TotalW-1:0]    total_t;
  typedef logic [MaskCount-1:0] grp_flags_t;

  // one base handed from the input register to the codon scanner
  typedef struct packed {
    logic             step;
    logic             last;
    logic [BaseW-1:0] base;
  } scan_step_t;

  // read-end update handed to the total accumulator
  typedef struct packed {
    logic            en;
    grp_flags_t      flags;
    logic [RptW-1:0] rpt;
  } acc_upd_t;

endpackage

FILE: sv/sfsc_base_if.sv
`timescale 1ns / 1ps
interface sfsc_base_if;
  import sfsc_pkg::*;

  logic            valid;
  logic            ready;
  logic [BaseW-1:0] base;
  logic            end_of_read;
  logic [RptW-1:0] repeat_count;

  modport source (output valid, output base, output end_of_read, output repeat_count,
                  input ready);
  modport sink (input valid, input base, input end_of_read, input repeat_count,
                output ready);
endinterface

FILE: sv/sfsc_result_if.sv
`timescale 1ns / 1ps
interface sfsc_result_if;
  import sfsc_pkg::*;

  logic         valid;
  logic         ready;
  logic [MaskCount-1:0] noncoding_flags;
  logic [TotalW-1:0] group_total_0;
  logic [TotalW-1:0] group_total_1;
  logic [TotalW-1:0] group_total_2;
  logic [TotalW-1:0] group_total_3;
  logic [TotalW-1:0] group_total_4;
  logic [TotalW-1:0] group_total_5;
  logic [TotalW-1:0] group_total_6;

  modport source (output valid, output noncoding_flags,
                  output group_total_0, output group_total_1, output group_total_2,
                  output group_total_3, output group_total_4, output group_total_5,
                  output group_total_6, input ready);
  modport sink (input valid, input noncoding_flags,
                input group_total_0, input group_total_1, input group_total_2,
                input group_total_3, input group_total_4, input group_total_5,
                input group_total_6, output ready);
endinterface

FILE: sv/six_frame_stop_codon_check_unit.sv
`timescale 1ns / 1ps
// Channel   Dir  Modport  Payload
// in_i      in   sink     base, end_of_read, repeat_count (one base per transfer)
// out_o     out  source   noncoding_flags, group_total_0..6 (one per read end)
// cfg_*     in   -        cfg_we_i, cfg_idx_i, cfg_data_i (stop mask writes)
//
// One base is taken per cycle; a read end loads the result register at the edge
// that moves it out of the input register. The scan is one pass of mask lookups,
// flag update and a 40-bit saturating add. Reset clears the read state and totals
// and loads the default stop masks. A read end waits in the input register while
// a result is still untaken and blocks the bases behind it; other bases pass
// regardless of the output.
module six_frame_stop_codon_check_unit #(
  parameter int unsigned MAX_READ_LEN = sfsc_pkg::DefaultMaxReadLen,
  parameter int unsigned NUM_GROUPS   = sfsc_pkg::DefaultNumGroups
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sfsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sfsc_pkg::MaskW-1:0]    cfg_data_i,
  sfsc_base_if.sink                     in_i,
  sfsc_result_if.source                 out_o
);
  import sfsc_pkg::*;

  mask_t [MaskCount-1:0] masks_q;

  logic             s1_vld_q;
  logic [BaseW-1:0] s1_base_q;
  logic             s1_eor_q;
  logic [RptW-1:0]  s1_rpt_q;

  logic                   out_vld_q;
  grp_flags_t             out_flags_q;
  total_t [MaskCount-1:0] out_tot_q;

  logic       out_free, s1_adv, in_xfer;
  scan_step_t step;
  acc_upd_t   upd;
  grp_flags_t flags;
  total_t [MaskCount-1:0] totals;

  assign out_free    = !out_vld_q || out_o.ready;
  assign s1_adv      = s1_vld_q && (!s1_eor_q || out_free);
  assign in_i.ready  = !s1_vld_q || s1_adv;
  assign in_xfer     = in_i.valid && in_i.ready;

  assign step.step = s1_adv;
  assign step.last = s1_eor_q;
  assign step.base = s1_base_q;

  assign upd.en    = s1_adv && s1_eor_q;
  assign upd.flags = flags;
  assign upd.rpt   = s1_rpt_q;

  sfsc_codon_scan #(
    .MAX_READ_LEN (MAX_READ_LEN),
    .NUM_GROUPS   (NUM_GROUPS)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .masks_i (masks_q),
    .flags_o (flags)
  );

  sfsc_total_acc u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (upd),
    .totals_o (totals)
  );

  // stop mask registers; an index past the last group is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      masks_q <= {MaskCount{DefaultStops}};
    end else if (cfg_we_i && (cfg_idx_i < CfgIdxW'(MaskCount))) begin
      masks_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_xfer) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_base_q <= in_i.base;
      s1_eor_q  <= in_i.end_of_read;
      s1_rpt_q  <= in_i.repeat_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (upd.en) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd.en) begin
      out_flags_q <= flags;
      out_tot_q   <= totals;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.noncoding_flags = out_flags_q;
  assign out_o.group_total_0   = out_tot_q[0];
  assign out_o.group_total_1   = out_tot_q[1];
  assign out_o.group_total_2   = out_tot_q[2];
  assign out_o.group_total_3   = out_tot_q[3];
  assign out_o.group_total_4   = out_tot_q[4];
  assign out_o.group_total_5   = out_tot_q[5];
  assign out_o.group_total_6   = out_tot_q[6];

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(s1_vld_q && s1_eor_q))
    else $error("result raised without a read end");

  a_read_end_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && s1_eor_q && out_vld_q && !out_o.ready) |=> s1_vld_q)
    else $error("stalled read end lost");

  a_xfer_captured: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> s1_vld_q)
    else $error("accepted base not held in input register");

endmodule

FILE: sv/sfsc_codon_scan.sv
`timescale 1ns / 1ps
module sfsc_codon_scan #(
  parameter int unsigned MAX_READ_LEN = sfsc_pkg::DefaultMaxReadLen,
  parameter int unsigned NUM_GROUPS   = sfsc_pkg::DefaultNumGroups
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  sfsc_pkg::scan_step_t                     step_i,
  input  sfsc_pkg::mask_t [sfsc_pkg::MaskCount-1:0] masks_i,
  output sfsc_pkg::grp_flags_t                     flags_o
);
  import sfsc_pkg::*;

  localparam int unsigned PosW       = $clog2(MAX_READ_LEN + 1);
  localparam int unsigned GroupsUsed = (NUM_GROUPS < MaskCount) ? NUM_GROUPS : MaskCount;

  logic [3:0]      prev_q, prev_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [1:0]      frame_q, frame_d;
  logic [MaskCount-1:0][2:0] fwd_q, fwd_d, rev_q, rev_d;
  logic [MaskCount-1:0][2:0] fwd_hit, rev_hit;

  logic       take, codon;
  logic [5:0] fwd_idx, rev_idx;
  logic [2:0] fbit;

  always_comb begin
    take    = step_i.step && (pos_q != PosW'(MAX_READ_LEN));
    codon   = take && (pos_q >= PosW'(2));
    fwd_idx = {prev_q, step_i.base};
    // reverse complement: reverse the bases, then 3-x of each, which is ~x
    rev_idx = ~{step_i.base, prev_q[1:0], prev_q[3:2]};
    fbit    = 3'b001 << frame_q;

    for (int g = 0; g < MaskCount; g++) begin
      fwd_hit[g] = fwd_q[g];
      rev_hit[g] = rev_q[g];
      if (codon && (g < GroupsUsed)) begin
        if (masks_i[g][fwd_idx]) fwd_hit[g] = fwd_q[g] | fbit;
        if (masks_i[g][rev_idx]) rev_hit[g] = rev_q[g] | fbit;
      end
      flags_o[g] = (&fwd_hit[g]) && (&rev_hit[g]);
    end

    prev_d  = prev_q;
    pos_d   = pos_q;
    frame_d = frame_q;
    fwd_d   = fwd_q;
    rev_d   = rev_q;
    if (step_i.step && step_i.last) begin
      prev_d  = '0;
      pos_d   = '0;
      frame_d = '0;
      fwd_d   = '0;
      rev_d   = '0;
    end else if (take) begin
      prev_d = {prev_q[1:0], step_i.base};
      pos_d  = pos_q + PosW'(1);
      fwd_d  = fwd_hit;
      rev_d  = rev_hit;
      if (codon) frame_d = (frame_q == 2'd2) ? 2'd0 : frame_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      pos_q   <= '0;
      frame_q <= '0;
      fwd_q   <= '0;
      rev_q   <= '0;
    end else begin
      prev_q  <= prev_d;
      pos_q   <= pos_d;
      frame_q <= frame_d;
      fwd_q   <= fwd_d;
      rev_q   <= rev_d;
    end
  end

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(MAX_READ_LEN))
    else $error("base position ran past the read length limit");

  a_frame_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_q != 2'd3)
    else $error("frame counter out of range");

  a_read_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i.step && step_i.last) |=> (pos_q == '0 && fwd_q == '0 && rev_q == '0))
    else $error("per-read state not cleared at read end");

endmodule

FILE: sv/sfsc_total_acc.sv
`timescale 1ns / 1ps
module sfsc_total_acc (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  sfsc_pkg::acc_upd_t                        upd_i,
  output sfsc_pkg::total_t [sfsc_pkg::MaskCount-1:0] totals_o
);
  import sfsc_pkg::*;

  total_t [MaskCount-1:0] tot_q, tot_d;
  logic [MaskCount-1:0][TotalW:0] sum;

  always_comb begin
    tot_d = tot_q;
    for (int g = 0; g < MaskCount; g++) begin
      sum[g] = {1'b0, tot_q[g]} + (TotalW + 1)'(upd_i.rpt);
      if (upd_i.en && upd_i.flags[g]) begin
        // carry out means the total would pass its maximum: hold at max
        tot_d[g] = sum[g][TotalW] ? TotalMax : sum[g][TotalW-1:0];
      end
    end
  end

  // the result register captures the totals including this read
  assign totals_o = tot_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q <= '0;
    end else begin
      tot_q <= tot_d;
    end
  end

  for (genvar g = 0; g < MaskCount; g++) begin : g_chk
    a_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
      tot_q[g] >= $past(tot_q[g]))
      else $error("group total decreased");
  end

endmodule

FILE: tb/six_frame_stop_codon_check_unit_tb.sv
`timescale 1ns / 1ps
module six_frame_stop_codon_check_unit_tb;
  import sfsc_pkg::*;

  localparam int unsigned MaxReadLen    = DefaultMaxReadLen;
  localparam int unsigned GroupsUsed    = (DefaultNumGroups < MaskCount) ? DefaultNumGroups
                                                                         : MaskCount;
  localparam logic [CfgIdxW-1:0] UnusedCfgIdx = CfgIdxW'(MaskCount);
  localparam int unsigned ProfileBases  = 150;
  localparam int unsigned BigReads      = 20;
  localparam int unsigned LongPrefix    = 48;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned MaxReported   = 10;
  // AAA and its reverse complement TTT
  localparam mask_t PolyAStops = {1'b1, 62'b0, 1'b1};

  typedef enum logic [BaseW-1:0] {
    BaseA = 2'd0,
    BaseC = 2'd1,
    BaseG = 2'd2,
    BaseT = 2'd3
  } base_code_e;

  typedef struct packed {
    grp_flags_t             flags;
    total_t [MaskCount-1:0] totals;
  } read_verdict_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  mask_t             cfg_data_i;

  sfsc_base_if   in_if ();
  sfsc_result_if out_if ();

  six_frame_stop_codon_check_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #4 clk_i = ~clk_i;

  // scan state mirrored from the block
  mask_t                  model_masks  [MaskCount];
  total_t                 model_totals [MaskCount];
  logic [3:0]             model_prev;
  int unsigned            model_pos;
  logic [3*MaskCount-1:0] model_fwd;
  logic [3*MaskCount-1:0] model_rev;
  read_verdict_t          expected_reads [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned bases_sent;
  int unsigned results_checked;
  int unsigned noncoding_reads;
  int unsigned mask_settings;
  int unsigned mismatches;
  int unsigned quiet_cycles = 0;

  task automatic clear_read_model();
    model_prev = '0;
    model_pos  = 0;
    model_fwd  = '0;
    model_rev  = '0;
  endtask

  task automatic predict_base(input logic [BaseW-1:0] b, input logic last,
                              input logic [RptW-1:0] rpt);
    logic [5:0]     fwd_codon;
    logic [5:0]     rev_codon;
    int unsigned    frame;
    grp_flags_t     flags;
    read_verdict_t  verdict;
    logic [TotalW:0] sum;
    if (model_pos < MaxReadLen) begin
      if (model_pos >= 2) begin
        frame     = (model_pos - 2) % 3;
        fwd_codon = {model_prev, b};
        // complement every base and reverse their order
        rev_codon = ~{b, model_prev[1:0], model_prev[3:2]};
        for (int g = 0; g < GroupsUsed; g++) begin
          if (model_masks[g][fwd_codon]) model_fwd[3*g+frame] = 1'b1;
          if (model_masks[g][rev_codon]) model_rev[3*g+frame] = 1'b1;
        end
      end
      model_prev = {model_prev[1:0], b};
      model_pos++;
    end
    if (last) begin
      flags = '0;
      for (int g = 0; g < GroupsUsed; g++) begin
        if (&model_fwd[3*g +: 3] && &model_rev[3*g +: 3]) begin
          flags[g] = 1'b1;
          sum = {1'b0, model_totals[g]} + (TotalW + 1)'(rpt);
          model_totals[g] = (sum > TotalMax) ? TotalMax : sum[TotalW-1:0];
        end
      end
      verdict.flags = flags;
      for (int g = 0; g < MaskCount; g++) verdict.totals[g] = model_totals[g];
      expected_reads.push_back(verdict);
      clear_read_model();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatches++;
    if (mismatches <= MaxReported)
      $display("mismatch on %s: expected %0h, got %0h (t=%0t)", what, want, got, $time);
  endtask

  task automatic check_read_result();
    read_verdict_t want;
    total_t        got [MaskCount];
    got[0] = out_if.group_total_0;
    got[1] = out_if.group_total_1;
    got[2] = out_if.group_total_2;
    got[3] = out_if.group_total_3;
    got[4] = out_if.group_total_4;
    got[5] = out_if.group_total_5;
    got[6] = out_if.group_total_6;
    if (expected_reads.size() == 0) begin
      report_mismatch("unexpected result, flags", '0, out_if.noncoding_flags);
      return;
    end
    want = expected_reads.pop_front();
    results_checked++;
    if (want.flags != '0) noncoding_reads++;
    if (out_if.noncoding_flags !== want.flags)
      report_mismatch("noncoding_flags", want.flags, out_if.noncoding_flags);
    for (int g = 0; g < MaskCount; g++) begin
      if (got[g] !== want.totals[g])
        report_mismatch($sformatf("group_total_%0d", g), want.totals[g], got[g]);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) check_read_result();
  end

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_base(input logic [BaseW-1:0] b, input logic last,
                           input logic [RptW-1:0] rpt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.base         <= b;
    in_if.end_of_read  <= last;
    in_if.repeat_count <= rpt;
    do @(posedge clk_i); while (!in_if.ready);
    predict_base(b, last, rpt);
    bases_sent++;
  endtask

  task automatic send_read(input string seq, input logic [RptW-1:0] rpt);
    base_code_e b;
    for (int i = 0; i < seq.len(); i++) begin
      case (seq[i])
        "A":     b = BaseA;
        "C":     b = BaseC;
        "G":     b = BaseG;
        default: b = BaseT;
      endcase
      send_base(b, i == seq.len() - 1, (i == seq.len() - 1) ? rpt : RptW'($urandom));
    end
  endtask

  task automatic send_random_read(input int unsigned len, input logic [RptW-1:0] rpt);
    for (int i = 0; i < len; i++)
      send_base(BaseW'($urandom_range(3)), i == len - 1,
                (i == len - 1) ? rpt : RptW'($urandom));
  endtask

  // hold off until the block has drained before touching its registers
  task automatic pause_for_config();
    in_if.valid <= 1'b0;
    while (expected_reads.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_mask(input logic [CfgIdxW-1:0] idx, input mask_t data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx < MaskCount) model_masks[idx] = data;
  endtask

  function automatic mask_t random_mask();
    mask_t m;
    m = {$urandom, $urandom};
    case ($urandom_range(5))
      0: m &= {$urandom, $urandom};
      1: m |= {$urandom, $urandom};
      2: m |= {$urandom, $urandom} | {$urandom, $urandom};
      3: m = DefaultStops | ({$urandom, $urandom} & {$urandom, $urandom});
      4: m = ($urandom_range(1)) ? '1 : '0;
      default: ;
    endcase
    return m;
  endfunction

  function automatic logic [RptW-1:0] random_repeat();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return RptW'($urandom);
    endcase
  endfunction

  task automatic load_random_masks();
    pause_for_config();
    for (int g = 0; g < MaskCount; g++) write_mask(CfgIdxW'(g), random_mask());
    mask_settings++;
  endtask

  task automatic test_directed();
    send_read("T", '1);
    send_read("TAAT", '1);
    send_read("TAATT", '0);
    pause_for_config();
    write_mask(CfgIdxW'(0), '1);
    write_mask(CfgIdxW'(1), '0);
    write_mask(CfgIdxW'(2), PolyAStops);
    // out-of-range index must leave every mask alone
    write_mask(UnusedCfgIdx, '1);
    mask_settings++;
    send_read("AAAAA", '1);
    send_read("CGTAC", 32'h8000_0001);
    send_read("GG", '0);
  endtask

  task automatic test_long_read();
    pause_for_config();
    for (int g = 0; g < MaskCount; g++) write_mask(CfgIdxW'(g), DefaultStops);
    mask_settings++;
    // a stop-free prefix, then stops in four of the six frames near the end of the read
    for (int i = 0; i < LongPrefix; i++) send_base(BaseC, 1'b0, RptW'($urandom));
    send_read("TAATTATAATCATTAG", RptW'($urandom));
  endtask

  task automatic test_random_reads();
    int unsigned first;
    load_random_masks();
    first = bases_sent;
    while (bases_sent - first < ProfileBases) begin
      if ($urandom_range(9) < 8) send_random_read($urandom_range(1, 12), random_repeat());
      else                       send_random_read($urandom_range(13, 48), random_repeat());
    end
  endtask

  task automatic test_large_totals();
    pause_for_config();
    for (int g = 0; g < MaskCount; g++) write_mask(CfgIdxW'(g), random_mask());
    write_mask(CfgIdxW'(3), '1);
    write_mask(CfgIdxW'(5), '0);
    mask_settings++;
    for (int r = 0; r < BigReads; r++) send_random_read(5, '1);
    send_random_read(5, RptW'($urandom));
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = '0;
    cfg_data_i          = '0;
    in_if.valid         = 1'b0;
    in_if.base          = '0;
    in_if.end_of_read   = 1'b0;
    in_if.repeat_count  = '0;
    out_if.ready        = 1'b0;
    bases_sent          = 0;
    results_checked     = 0;
    noncoding_reads     = 0;
    mask_settings       = 0;
    mismatches          = 0;
    for (int g = 0; g < MaskCount; g++) begin
      model_masks[g]  = DefaultStops;
      model_totals[g] = '0;
    end
    clear_read_model();
    send_idle_pct = 9;
    recv_idle_pct = 66;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_long_read();
    test_random_reads();
    send_idle_pct = 66;
    recv_idle_pct = 9;
    test_random_reads();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_reads();
    test_large_totals();

    in_if.valid <= 1'b0;
    while (expected_reads.size() != 0) @(posedge clk_i);
    repeat (2 * SettleCycles) @(posedge clk_i);

    $display("covered %0d bases and %0d read results, %0d of them with a noncoding group",
             bases_sent, results_checked, noncoding_reads);
    $display("covered %0d mask settings, one long read and a run of maximum repeat counts",
             mask_settings);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
